>>> rtl/half_ellipse_band_vertex_generator_unit_defines.svh
// Assertion macros shared by the vertex generator.
`ifndef HALF_ELLIPSE_BAND_VERTEX_GENERATOR_UNIT_DEFINES_SVH
`define HALF_ELLIPSE_BAND_VERTEX_GENERATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check an implication on every rising clock edge outside reset.
`define HEBV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define HEBV_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HEBV_ASSERT(label, clk, rst_n, prop, msg)
`define HEBV_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

>>> rtl/hebv_pkg.sv
`timescale 1ns / 1ps
package hebv_pkg;

  // Sizing
  localparam int MAX_POINTS    = 64;
  localparam int MIN_POINTS    = 3;
  localparam int CORDIC_STAGES = 16;
  localparam int CS_W          = $clog2(CORDIC_STAGES);

  localparam int IDX_W   = 7;
  localparam int PC_W    = 7;
  localparam int RAD_W   = 15;
  localparam int COORD_W = 16;
  localparam int NM1_W   = $clog2(MAX_POINTS);
  localparam int D_W     = NM1_W + 1;

  // Angle is in units of pi/65536; the quotient covers 0 .. 2^16
  localparam int ANG_HALF_W = 16;
  localparam int Q_W        = ANG_HALF_W + 1;
  localparam int DIV_STEPS  = Q_W;
  localparam int MAG_W      = Q_W - 1;

  // Radian conversion: pi in Q44, split in two partial products
  localparam int PIP_W   = 23;
  localparam int PPROD_W = MAG_W + PIP_W;
  localparam int SUM_W   = PPROD_W + PIP_W;
  localparam logic [2*PIP_W-1:0] PI_Q44 = 46'h3243F6A8885A;
  localparam logic [PIP_W-1:0]   PI_HI  = PI_Q44[2*PIP_W-1:PIP_W];
  localparam logic [PIP_W-1:0]   PI_LO  = PI_Q44[PIP_W-1:0];

  // CORDIC datapath, Q30
  localparam int TRIG_W = 32;
  localparam int FRAC_W = 30;
  localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 32'sh26DD3B6A;
  localparam logic [SUM_W-1:0] Z_ROUND = SUM_W'(1) << (FRAC_W - 1);

  // Coordinate scaling
  localparam int PROD_W = RAD_W + 1 + TRIG_W;
  localparam int SHR_W  = PROD_W - FRAC_W;
  localparam logic signed [PROD_W-1:0] P_ROUND   = PROD_W'(1) << (FRAC_W - 1);
  localparam logic signed [SHR_W-1:0]  COORD_MAX = SHR_W'(32767);
  localparam logic signed [SHR_W-1:0]  COORD_MIN = -SHR_W'(32767);

  // Register map
  typedef enum logic [1:0] {
    REG_FIRST_RAD   = 2'd0,
    REG_SECOND_RAD  = 2'd1,
    REG_VERT_RAD    = 2'd2,
    REG_POINT_COUNT = 2'd3
  } reg_addr_e;

  // Per-word side information carried along the pipe
  typedef struct packed {
    logic sel_second;
    logic is_last;
    logic err;
  } tag_t;

  // Restoring divider state
  typedef struct packed {
    logic [D_W-1:0]   rem;
    logic [Q_W-1:0]   quo;
    logic [Q_W-1:0]   nrem;
    logic [NM1_W-1:0] nm1;
  } div_t;

  // CORDIC rotation state
  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
  } cordic_t;

  // atan(2^-j) in Q30, rounded
  function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [CS_W-1:0] j);
    logic signed [TRIG_W-1:0] r;
    case (int'(j))
      0:       r = 32'sd843314857;
      1:       r = 32'sd497837829;
      2:       r = 32'sd263043837;
      3:       r = 32'sd133525159;
      4:       r = 32'sd67021687;
      5:       r = 32'sd33543516;
      6:       r = 32'sd16775851;
      7:       r = 32'sd8388437;
      8:       r = 32'sd4194283;
      9:       r = 32'sd2097149;
      10:      r = 32'sd1048576;
      11:      r = 32'sd524288;
      default: r = 32'sh4000_0000 >>> j;
    endcase
    return r;
  endfunction

  // Round a Q30-scaled product back to Q11.4 and clamp to the symmetric range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [SHR_W-1:0]  v;
    logic signed [COORD_W-1:0] r;
    s = p + P_ROUND;
    v = s[PROD_W-1:FRAC_W];
    if (v > COORD_MAX) begin
      r = COORD_W'(COORD_MAX);
    end else if (v < COORD_MIN) begin
      r = COORD_W'(COORD_MIN);
    end else begin
      r = COORD_W'(v);
    end
    return r;
  endfunction

endpackage

>>> rtl/hebv_div_cell.sv
`timescale 1ns / 1ps
module hebv_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  hebv_pkg::div_t data_i,
  input  hebv_pkg::tag_t tag_i,
  output logic          valid_o,
  input  logic          ready_i,
  output hebv_pkg::div_t data_o,
  output hebv_pkg::tag_t tag_o
);
  import hebv_pkg::*;

  logic           valid_q;
  div_t           data_q;
  div_t           data_d;
  tag_t           tag_q;
  logic [D_W:0]   trial;
  logic [D_W-1:0] divisor;
  logic           fits;

  // Load when empty or when the next cell takes our word
  assign ready_o = !valid_q || ready_i;

  // One quotient bit: shift in the next numerator bit, subtract if it fits
  always_comb begin
    divisor     = {data_i.nm1, 1'b0};
    trial       = {data_i.rem, data_i.nrem[Q_W-1]};
    fits        = trial >= {1'b0, divisor};
    data_d      = data_i;
    data_d.rem  = fits ? D_W'(trial - {1'b0, divisor}) : D_W'(trial);
    data_d.quo  = {data_i.quo[Q_W-2:0], fits};
    data_d.nrem = {data_i.nrem[Q_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
      tag_q  <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign tag_o   = tag_q;

endmodule

>>> rtl/hebv_cordic_cell.sv
`timescale 1ns / 1ps
module hebv_cordic_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [hebv_pkg::CS_W-1:0]   stage_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  hebv_pkg::cordic_t           data_i,
  input  hebv_pkg::tag_t              tag_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output hebv_pkg::cordic_t           data_o,
  output hebv_pkg::tag_t              tag_o
);
  import hebv_pkg::*;

  logic                     valid_q;
  cordic_t                  data_q;
  cordic_t                  data_d;
  tag_t                     tag_q;
  logic signed [TRIG_W-1:0] dx;
  logic signed [TRIG_W-1:0] dy;
  logic signed [TRIG_W-1:0] ang;

  assign ready_o = !valid_q || ready_i;

  // Rotate toward zero residual angle
  always_comb begin
    dx  = data_i.y >>> stage_i;
    dy  = data_i.x >>> stage_i;
    ang = atan_q30(stage_i);
    if (!data_i.z[TRIG_W-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ang;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
      tag_q  <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign tag_o   = tag_q;

endmodule

>>> rtl/half_ellipse_band_vertex_generator_unit.sv
`timescale 1ns / 1ps
`include "half_ellipse_band_vertex_generator_unit_defines.svh"
// Half-ellipse band vertex generator. Each input word carries a triangle-strip
// vertex index and yields one result word with the vertex (x, y) in signed
// Q11.4, an end-of-strip flag and an out-of-range flag (coordinates zero).
// The block takes one word per cycle while the output is not stalled and returns
// results in order through a decode stage, a 17-cell restoring divider that
// turns the index into an angle, four stages that convert the angle to Q30
// radians, one CORDIC cell per rotation step, then a multiply stage and a
// round/clamp output register. Every cell moves its word on as soon as the next
// cell has room, so gaps close up while the output is stalled. Radii and point
// count sit in an APB register file at byte offsets 0, 4, 8 and 12; write them
// only while no word is in flight.
module half_ellipse_band_vertex_generator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Index input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [hebv_pkg::IDX_W-1:0]         vertex_index_i,
  // Vertex output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [hebv_pkg::COORD_W-1:0] x_pos_o,
  output logic signed [hebv_pkg::COORD_W-1:0] y_pos_o,
  output logic                               is_last_o,
  output logic                               index_error_o
);
  import hebv_pkg::*;

  // ---------------------------------------------------------------------
  // Register file
  logic [RAD_W-1:0] first_rad_q;
  logic [RAD_W-1:0] second_rad_q;
  logic [RAD_W-1:0] vert_rad_q;
  logic [PC_W-1:0]  point_count_q;
  logic             cfg_wr;
  reg_addr_e        cfg_addr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_addr = reg_addr_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_rad_q   <= '0;
      second_rad_q  <= '0;
      vert_rad_q    <= '0;
      point_count_q <= PC_W'(32);
    end else if (cfg_wr) begin
      case (cfg_addr)
        REG_FIRST_RAD:   first_rad_q   <= pwdata[RAD_W-1:0];
        REG_SECOND_RAD:  second_rad_q  <= pwdata[RAD_W-1:0];
        REG_VERT_RAD:    vert_rad_q    <= pwdata[RAD_W-1:0];
        REG_POINT_COUNT: point_count_q <= pwdata[PC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_addr)
      REG_FIRST_RAD:   prdata = 32'(first_rad_q);
      REG_SECOND_RAD:  prdata = 32'(second_rad_q);
      REG_VERT_RAD:    prdata = 32'(vert_rad_q);
      REG_POINT_COUNT: prdata = 32'(point_count_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipe handshake signals
  logic    s0_v_q, s0_rdy;
  div_t    s0_q;
  tag_t    s0_tag_q;

  logic    div_v   [DIV_STEPS+1];
  logic    div_rdy [DIV_STEPS+1];
  div_t    div_w   [DIV_STEPS+1];
  tag_t    div_tag [DIV_STEPS+1];

  logic                   sa_v_q, sa_rdy;
  logic [MAG_W-1:0]       sa_mag_q;
  logic                   sa_neg_q;
  tag_t                   sa_tag_q;

  logic                   sm_v_q, sm_rdy;
  logic [PPROD_W-1:0]     sm_hi_q;
  logic [PPROD_W-1:0]     sm_lo_q;
  logic                   sm_neg_q;
  tag_t                   sm_tag_q;

  logic                   sz_v_q, sz_rdy;
  logic [TRIG_W-2:0]      sz_mag_q;
  logic                   sz_neg_q;
  tag_t                   sz_tag_q;

  logic                   sn_v_q, sn_rdy;
  cordic_t                sn_q;
  tag_t                   sn_tag_q;

  logic    cor_v   [CORDIC_STAGES+1];
  logic    cor_rdy [CORDIC_STAGES+1];
  cordic_t cor_w   [CORDIC_STAGES+1];
  tag_t    cor_tag [CORDIC_STAGES+1];

  logic                     sp_v_q, sp_rdy;
  logic signed [PROD_W-1:0] sp_x_q;
  logic signed [PROD_W-1:0] sp_y_q;
  tag_t                     sp_tag_q;

  logic                      so_v_q, so_rdy;
  logic signed [COORD_W-1:0] so_x_q;
  logic signed [COORD_W-1:0] so_y_q;
  logic                      so_last_q;
  logic                      so_err_q;

  // ---------------------------------------------------------------------
  // Decode: clamp N, check range, pick the angle step and the radius
  logic [PC_W-1:0]  n_clamp;
  logic [PC_W:0]    last_idx;
  logic [IDX_W:0]   k_inc;
  logic             k_err;
  logic [NM1_W-1:0] step_i;
  logic [NM1_W-1:0] nm1;

  always_comb begin
    if (point_count_q < PC_W'(MIN_POINTS)) begin
      n_clamp = PC_W'(MIN_POINTS);
    end else if (point_count_q > PC_W'(MAX_POINTS)) begin
      n_clamp = PC_W'(MAX_POINTS);
    end else begin
      n_clamp = point_count_q;
    end
    last_idx = {n_clamp, 1'b0} - (PC_W+1)'(3);
    k_err    = {1'b0, vertex_index_i} > last_idx;
    k_inc    = {1'b0, vertex_index_i} + (IDX_W+1)'(1);
    step_i   = k_err ? '0 : k_inc[NM1_W:1];
    nm1      = NM1_W'(n_clamp - PC_W'(1));
  end

  assign s0_rdy     = !s0_v_q || div_rdy[0];
  assign in_ready_o = s0_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (s0_rdy) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_rdy && in_valid_i) begin
      s0_q.rem            <= D_W'(step_i);
      s0_q.quo            <= '0;
      s0_q.nrem           <= Q_W'(nm1);
      s0_q.nm1            <= nm1;
      s0_tag_q.sel_second <= !vertex_index_i[0] && (vertex_index_i != '0);
      s0_tag_q.is_last    <= !k_err && ({1'b0, vertex_index_i} == last_idx);
      s0_tag_q.err        <= k_err;
    end
  end

  // ---------------------------------------------------------------------
  // Divider chain: angle = round(step * 65536 / (N-1))
  assign div_v[0]   = s0_v_q;
  assign div_w[0]   = s0_q;
  assign div_tag[0] = s0_tag_q;
  assign div_rdy[DIV_STEPS] = sa_rdy;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    hebv_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_v[g]),
      .ready_o (div_rdy[g]),
      .data_i  (div_w[g]),
      .tag_i   (div_tag[g]),
      .valid_o (div_v[g+1]),
      .ready_i (div_rdy[g+1]),
      .data_o  (div_w[g+1]),
      .tag_o   (div_tag[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // Center the angle on zero and split off the sign
  localparam logic [Q_W-1:0] ANG_HALF = Q_W'(1) << (Q_W - 2);
  logic [Q_W-1:0] quo;
  logic           quo_neg;

  assign quo     = div_w[DIV_STEPS].quo;
  assign quo_neg = quo < ANG_HALF;
  assign sa_rdy  = !sa_v_q || sm_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_v_q <= 1'b0;
    end else if (sa_rdy) begin
      sa_v_q <= div_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sa_rdy && div_v[DIV_STEPS]) begin
      sa_mag_q <= quo_neg ? MAG_W'(ANG_HALF - quo) : MAG_W'(quo - ANG_HALF);
      sa_neg_q <= quo_neg;
      sa_tag_q <= div_tag[DIV_STEPS];
    end
  end

  // Multiply the magnitude by pi in two halves
  assign sm_rdy = !sm_v_q || sz_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_v_q <= 1'b0;
    end else if (sm_rdy) begin
      sm_v_q <= sa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sm_rdy && sa_v_q) begin
      sm_hi_q  <= PPROD_W'(sa_mag_q) * PPROD_W'(PI_HI);
      sm_lo_q  <= PPROD_W'(sa_mag_q) * PPROD_W'(PI_LO);
      sm_neg_q <= sa_neg_q;
      sm_tag_q <= sa_tag_q;
    end
  end

  // Sum the halves and round to Q30 radians
  logic [SUM_W-1:0] z_sum;

  assign z_sum  = {sm_hi_q, PIP_W'(0)} + SUM_W'(sm_lo_q) + Z_ROUND;
  assign sz_rdy = !sz_v_q || sn_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sz_v_q <= 1'b0;
    end else if (sz_rdy) begin
      sz_v_q <= sm_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sz_rdy && sm_v_q) begin
      sz_mag_q <= z_sum[FRAC_W+TRIG_W-2:FRAC_W];
      sz_neg_q <= sm_neg_q;
      sz_tag_q <= sm_tag_q;
    end
  end

  // Apply the sign and seed the rotation vector
  logic signed [TRIG_W-1:0] z_pos;

  assign z_pos  = $signed({1'b0, sz_mag_q});
  assign sn_rdy = !sn_v_q || cor_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sn_v_q <= 1'b0;
    end else if (sn_rdy) begin
      sn_v_q <= sz_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sn_rdy && sz_v_q) begin
      sn_q.x   <= GAIN_Q30;
      sn_q.y   <= '0;
      sn_q.z   <= sz_neg_q ? -z_pos : z_pos;
      sn_tag_q <= sz_tag_q;
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC chain
  assign cor_v[0]   = sn_v_q;
  assign cor_w[0]   = sn_q;
  assign cor_tag[0] = sn_tag_q;
  assign cor_rdy[CORDIC_STAGES] = sp_rdy;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    hebv_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (CS_W'(g)),
      .valid_i (cor_v[g]),
      .ready_o (cor_rdy[g]),
      .data_i  (cor_w[g]),
      .tag_i   (cor_tag[g]),
      .valid_o (cor_v[g+1]),
      .ready_i (cor_rdy[g+1]),
      .data_o  (cor_w[g+1]),
      .tag_o   (cor_tag[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // Scale cosine and sine by the radii
  logic [RAD_W-1:0] horiz_rad;

  assign horiz_rad = cor_tag[CORDIC_STAGES].sel_second ? second_rad_q : first_rad_q;
  assign sp_rdy    = !sp_v_q || so_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_v_q <= 1'b0;
    end else if (sp_rdy) begin
      sp_v_q <= cor_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sp_rdy && cor_v[CORDIC_STAGES]) begin
      sp_x_q   <= $signed({1'b0, horiz_rad}) * cor_w[CORDIC_STAGES].x;
      sp_y_q   <= $signed({1'b0, vert_rad_q}) * cor_w[CORDIC_STAGES].y;
      sp_tag_q <= cor_tag[CORDIC_STAGES];
    end
  end

  // Round, clamp and hold the result word
  assign so_rdy = !so_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      so_v_q <= 1'b0;
    end else if (so_rdy) begin
      so_v_q <= sp_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (so_rdy && sp_v_q) begin
      so_x_q    <= sp_tag_q.err ? '0 : sat_coord(sp_x_q);
      so_y_q    <= sp_tag_q.err ? '0 : sat_coord(sp_y_q);
      so_last_q <= sp_tag_q.is_last;
      so_err_q  <= sp_tag_q.err;
    end
  end

  assign out_valid_o   = so_v_q;
  assign x_pos_o       = so_x_q;
  assign y_pos_o       = so_y_q;
  assign is_last_o     = so_last_q;
  assign index_error_o = so_err_q;

  // ---------------------------------------------------------------------
  // Checks
  `HEBV_ASSERT(a_err_zero, clk_i, rst_ni, out_valid_o && index_error_o |-> x_pos_o == '0 && y_pos_o == '0 && !is_last_o, "out-of-range word carries data")
  `HEBV_ASSERT(a_stall_cause, clk_i, rst_ni, !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled without output backpressure")
  `HEBV_ASSERT_NEVER(a_clamp, clk_i, rst_ni, out_valid_o && (x_pos_o == 16'sh8000 || y_pos_o == 16'sh8000), "coordinate outside clamp range")

endmodule
